// ===== hdl/fac_pkg.sv =====
package fac_pkg;

   // plane rows held by the chain, one per cell
   localparam int NUM_PLANES = 6;

   localparam int NORMAL_W = 24;
   localparam int OFFSET_W = 40;
   localparam int COORD_W  = 16;
   localparam int INDEX_W  = 3;
   localparam int PROD_W   = NORMAL_W + COORD_W;
   // three products plus the offset: 43 bits are enough, never overflows
   localparam int SUM_W    = OFFSET_W + 3;

   localparam int CELL_ID_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
   localparam int CMP_W     = (CELL_ID_W > INDEX_W) ? CELL_ID_W : INDEX_W;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TEST = 1'b1;

   typedef struct packed {
      logic                       opcode;
      logic [INDEX_W-1:0]         plane_index;
      logic signed [NORMAL_W-1:0] plane_a;
      logic signed [NORMAL_W-1:0] plane_b;
      logic signed [NORMAL_W-1:0] plane_c;
      logic signed [OFFSET_W-1:0] plane_d;
      logic signed [COORD_W-1:0]  box_min_x;
      logic signed [COORD_W-1:0]  box_min_y;
      logic signed [COORD_W-1:0]  box_min_z;
      logic signed [COORD_W-1:0]  box_max_x;
      logic signed [COORD_W-1:0]  box_max_y;
      logic signed [COORD_W-1:0]  box_max_z;
   } req_payload_type;

   typedef struct packed {
      logic visible;
   } rsp_payload_type;

   // one beat as it travels down the chain; box corners already ordered
   typedef struct packed {
      logic                       valid;
      logic                       opcode;
      logic [INDEX_W-1:0]         plane_index;
      logic signed [NORMAL_W-1:0] plane_a;
      logic signed [NORMAL_W-1:0] plane_b;
      logic signed [NORMAL_W-1:0] plane_c;
      logic signed [OFFSET_W-1:0] plane_d;
      logic signed [COORD_W-1:0]  lo_x;
      logic signed [COORD_W-1:0]  lo_y;
      logic signed [COORD_W-1:0]  lo_z;
      logic signed [COORD_W-1:0]  hi_x;
      logic signed [COORD_W-1:0]  hi_y;
      logic signed [COORD_W-1:0]  hi_z;
      logic                       visible;
   } item_type;

endpackage

// ===== hdl/fac_if.sv =====
interface fac_req_if;
   logic                     valid;
   logic                     ready;
   fac_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface fac_rsp_if;
   logic                     valid;
   logic                     ready;
   fac_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/fac_cell.sv =====
module fac_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic [fac_pkg::CELL_ID_W-1:0]     cell_id,
   input  fac_pkg::item_type                 item_in,
   output fac_pkg::item_type                 item_out
);

   // plane row held by this cell
   logic signed [fac_pkg::NORMAL_W-1:0] row_a_ff, row_b_ff, row_c_ff;
   logic signed [fac_pkg::OFFSET_W-1:0] row_d_ff;

   // first stage: products and offset of this row
   fac_pkg::item_type                   mid_item_ff, mid_item_in;
   logic signed [fac_pkg::PROD_W-1:0]   px_ff, py_ff, pz_ff, px_in, py_in, pz_in;
   logic signed [fac_pkg::OFFSET_W-1:0] md_ff;

   fac_pkg::item_type                   out_ff, out_in;

   logic signed [fac_pkg::COORD_W-1:0]  sel_x, sel_y, sel_z;
   logic signed [fac_pkg::SUM_W-1:0]    sum;
   logic                                hit;

   // load beat addressed to this cell
   assign hit = item_in.valid && (item_in.opcode == fac_pkg::OP_LOAD) &&
                (fac_pkg::CMP_W'(item_in.plane_index) == fac_pkg::CMP_W'(cell_id));

   // best corner per axis: a negative coefficient favours the low coordinate
   always_comb begin
      sel_x = row_a_ff[fac_pkg::NORMAL_W-1] ? item_in.lo_x : item_in.hi_x;
      sel_y = row_b_ff[fac_pkg::NORMAL_W-1] ? item_in.lo_y : item_in.hi_y;
      sel_z = row_c_ff[fac_pkg::NORMAL_W-1] ? item_in.lo_z : item_in.hi_z;
      px_in = row_a_ff * sel_x;
      py_in = row_b_ff * sel_y;
      pz_in = row_c_ff * sel_z;
      mid_item_in = item_in;
   end

   // second stage: sum and strict sign check
   always_comb begin
      sum = {{3{px_ff[fac_pkg::PROD_W-1]}}, px_ff} +
            {{3{py_ff[fac_pkg::PROD_W-1]}}, py_ff} +
            {{3{pz_ff[fac_pkg::PROD_W-1]}}, pz_ff} +
            {{3{md_ff[fac_pkg::OFFSET_W-1]}}, md_ff};
      out_in = mid_item_ff;
      if (mid_item_ff.opcode == fac_pkg::OP_TEST) begin
         out_in.visible = mid_item_ff.visible && (sum > 0);
      end
   end

   // row storage
   always_ff @(posedge clock) begin
      if (reset) begin
         row_a_ff <= '0;
         row_b_ff <= '0;
         row_c_ff <= '0;
         row_d_ff <= '0;
      end else if (advance && hit) begin
         row_a_ff <= item_in.plane_a;
         row_b_ff <= item_in.plane_b;
         row_c_ff <= item_in.plane_c;
         row_d_ff <= item_in.plane_d;
      end
   end

   // stage registers: valid bits reset, payload only moves
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_item_ff.valid <= 1'b0;
         out_ff.valid      <= 1'b0;
      end else if (advance) begin
         mid_item_ff.valid <= mid_item_in.valid;
         out_ff.valid      <= out_in.valid;
      end
      if (advance) begin
         mid_item_ff.opcode      <= mid_item_in.opcode;
         mid_item_ff.plane_index <= mid_item_in.plane_index;
         mid_item_ff.plane_a     <= mid_item_in.plane_a;
         mid_item_ff.plane_b     <= mid_item_in.plane_b;
         mid_item_ff.plane_c     <= mid_item_in.plane_c;
         mid_item_ff.plane_d     <= mid_item_in.plane_d;
         mid_item_ff.lo_x        <= mid_item_in.lo_x;
         mid_item_ff.lo_y        <= mid_item_in.lo_y;
         mid_item_ff.lo_z        <= mid_item_in.lo_z;
         mid_item_ff.hi_x        <= mid_item_in.hi_x;
         mid_item_ff.hi_y        <= mid_item_in.hi_y;
         mid_item_ff.hi_z        <= mid_item_in.hi_z;
         mid_item_ff.visible     <= mid_item_in.visible;
         px_ff                   <= px_in;
         py_ff                   <= py_in;
         pz_ff                   <= pz_in;
         md_ff                   <= row_d_ff;
         out_ff.opcode           <= out_in.opcode;
         out_ff.plane_index      <= out_in.plane_index;
         out_ff.plane_a          <= out_in.plane_a;
         out_ff.plane_b          <= out_in.plane_b;
         out_ff.plane_c          <= out_in.plane_c;
         out_ff.plane_d          <= out_in.plane_d;
         out_ff.lo_x             <= out_in.lo_x;
         out_ff.lo_y             <= out_in.lo_y;
         out_ff.lo_z             <= out_in.lo_z;
         out_ff.hi_x             <= out_in.hi_x;
         out_ff.hi_y             <= out_in.hi_y;
         out_ff.hi_z             <= out_in.hi_z;
         out_ff.visible          <= out_in.visible;
      end
   end

   assign item_out = out_ff;

endmodule

// ===== hdl/frustum_aabb_cull_test.sv =====
// Path: the accepting edge loads a test beat into the entry register, then
// the beat passes two stages per plane cell before its result is offered.
// Throughput: one beat per cycle while the result side takes beats; the whole
// chain holds when a result is waiting and not taken.
// Reset (synchronous, active high) empties the chain and clears every plane row
// to zero, so every box is culled until rows are loaded.
module frustum_aabb_cull_test (
   input  logic             clock,
   input  logic             reset,
   fac_req_if.sink          req_chan,
   fac_rsp_if.source        rsp_chan
);

   fac_pkg::item_type entry_ff, entry_in;
   fac_pkg::item_type chain [fac_pkg::NUM_PLANES+1];
   fac_pkg::item_type last_item;
   logic              advance;

   assign last_item = chain[fac_pkg::NUM_PLANES];

   // the chain moves unless a finished result is stuck at the end
   assign advance = !(last_item.valid && (last_item.opcode == fac_pkg::OP_TEST)) ||
                    rsp_chan.ready;
   assign req_chan.ready = advance;

   // order each axis so the cells only pick by coefficient sign
   always_comb begin
      entry_in.valid       = req_chan.valid;
      entry_in.opcode      = req_chan.payload.opcode;
      entry_in.plane_index = req_chan.payload.plane_index;
      entry_in.plane_a     = req_chan.payload.plane_a;
      entry_in.plane_b     = req_chan.payload.plane_b;
      entry_in.plane_c     = req_chan.payload.plane_c;
      entry_in.plane_d     = req_chan.payload.plane_d;
      if ($signed(req_chan.payload.box_min_x) <= $signed(req_chan.payload.box_max_x)) begin
         entry_in.lo_x = req_chan.payload.box_min_x;
         entry_in.hi_x = req_chan.payload.box_max_x;
      end else begin
         entry_in.lo_x = req_chan.payload.box_max_x;
         entry_in.hi_x = req_chan.payload.box_min_x;
      end
      if ($signed(req_chan.payload.box_min_y) <= $signed(req_chan.payload.box_max_y)) begin
         entry_in.lo_y = req_chan.payload.box_min_y;
         entry_in.hi_y = req_chan.payload.box_max_y;
      end else begin
         entry_in.lo_y = req_chan.payload.box_max_y;
         entry_in.hi_y = req_chan.payload.box_min_y;
      end
      if ($signed(req_chan.payload.box_min_z) <= $signed(req_chan.payload.box_max_z)) begin
         entry_in.lo_z = req_chan.payload.box_min_z;
         entry_in.hi_z = req_chan.payload.box_max_z;
      end else begin
         entry_in.lo_z = req_chan.payload.box_max_z;
         entry_in.hi_z = req_chan.payload.box_min_z;
      end
      entry_in.visible = 1'b1;
   end

   // entry register: valid bit resets, payload only moves
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else if (advance) begin
         entry_ff.valid <= entry_in.valid;
      end
      if (advance) begin
         entry_ff.opcode      <= entry_in.opcode;
         entry_ff.plane_index <= entry_in.plane_index;
         entry_ff.plane_a     <= entry_in.plane_a;
         entry_ff.plane_b     <= entry_in.plane_b;
         entry_ff.plane_c     <= entry_in.plane_c;
         entry_ff.plane_d     <= entry_in.plane_d;
         entry_ff.lo_x        <= entry_in.lo_x;
         entry_ff.lo_y        <= entry_in.lo_y;
         entry_ff.lo_z        <= entry_in.lo_z;
         entry_ff.hi_x        <= entry_in.hi_x;
         entry_ff.hi_y        <= entry_in.hi_y;
         entry_ff.hi_z        <= entry_in.hi_z;
         entry_ff.visible     <= entry_in.visible;
      end
   end

   assign chain[0] = entry_ff;

   // one cell per plane row; loads and tests travel in order
   for (genvar g = 0; g < fac_pkg::NUM_PLANES; g++) begin : g_cell
      fac_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cell_id  (fac_pkg::CELL_ID_W'(g)),
         .item_in  (chain[g]),
         .item_out (chain[g+1])
      );
   end

   // load beats leave the chain silently
   assign rsp_chan.valid           = last_item.valid && (last_item.opcode == fac_pkg::OP_TEST);
   assign rsp_chan.payload.visible = last_item.visible;

endmodule
